@@ hdl/dmc_pkg.sv @@
// Shared constants and control/status types for the direct-mapped cache.
// Used by the controller, the datapath and the top level; depends on nothing.
package dmc_pkg;

	localparam int NUM_LINES    = 4;
	localparam int BLOCK_BYTES  = 8;
	localparam int MEMORY_BYTES = 1024;

	localparam int ADDR_W  = 10;
	localparam int BYTE_W  = 8;
	localparam int CNT_W   = 32;
	localparam int OFF_W   = $clog2(BLOCK_BYTES);
	localparam int LINE_W  = $clog2(NUM_LINES);
	localparam int TAG_W   = ADDR_W - OFF_W - LINE_W;
	localparam int MEM_AW  = $clog2(MEMORY_BYTES);
	localparam int LRAM_AW = LINE_W + OFF_W;

	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = BYTE_W + 2 * CNT_W;

	localparam logic [BYTE_W-1:0] PENALTY_RESET = BYTE_W'(10);
	localparam logic [CNT_W-1:0]  CNT_MAX       = {CNT_W{1'b1}};

	localparam logic MODE_LOAD = 1'b0;

	typedef struct packed {
		logic accept;
		logic lookup;
		logic fill_step;
		logic publish;
	} dmc_cmd_t;

	typedef struct packed {
		logic hit;
		logic fill_last;
		logic out_free;
	} dmc_sts_t;

endpackage

@@ hdl/dmc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dmc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ hdl/dmc_ctrl.sv @@
// Sequencer for the cache: accept, tag lookup, block fill, result hand-off.
// Depends on dmc_pkg.
module dmc_ctrl
	import dmc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_axis_tvalid,
	output logic     s_axis_tready,
	input  logic     s_axis_tuser,
	input  dmc_sts_t sts,
	output dmc_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_FILL,
		ST_DRAIN,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   ready_q;
	logic   accept;

	assign accept        = s_axis_tvalid & ready_q;
	assign s_axis_tready = ready_q;

	always_comb begin
		cmd           = '0;
		cmd.accept    = accept;
		cmd.lookup    = (state_q == ST_LOOKUP);
		cmd.fill_step = (state_q == ST_FILL);
		cmd.publish   = (state_q == ST_DONE) & sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ready_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						ready_q <= 1'b0;
						state_q <= (s_axis_tuser == MODE_LOAD) ? ST_DONE : ST_LOOKUP;
					end else begin
						ready_q <= 1'b1;
					end
				end
				ST_LOOKUP: begin
					state_q <= sts.hit ? ST_DONE : ST_FILL;
				end
				ST_FILL: begin
					if (sts.fill_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (sts.out_free) begin
						ready_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					ready_q <= 1'b0;
				end
			endcase
		end
	end

endmodule

@@ hdl/dmc_datapath.sv @@
// Cache datapath: tag/valid store, line and backing RAMs, counters, output register.
// Depends on dmc_pkg and dmc_ram.
module dmc_datapath
	import dmc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  dmc_cmd_t               cmd,
	output dmc_sts_t               sts,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	input  logic                   s_axis_tuser,
	input  logic                   cfg_we,
	input  logic [BYTE_W-1:0]      cfg_wdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	output logic                   m_axis_tuser
);

	logic [ADDR_W-1:0] in_addr;
	logic [BYTE_W-1:0] in_byte;

	logic [ADDR_W-1:0] addr_q;
	logic [BYTE_W-1:0] penalty_q;
	logic [TAG_W-1:0]  tag_q   [NUM_LINES];
	logic [NUM_LINES-1:0] valid_q;
	logic [CNT_W-1:0]  miss_q;
	logic [CNT_W-1:0]  elapsed_q;
	logic              hit_q;
	logic [BYTE_W-1:0] byte_q;
	logic [OFF_W-1:0]  fill_cnt_q;
	logic              fill_pend_s1;
	logic [OFF_W-1:0]  fill_idx_s1;
	logic              m_valid_q;

	logic [LINE_W-1:0] line;
	logic [TAG_W-1:0]  tag;
	logic [OFF_W-1:0]  offset;
	logic              hit;
	logic [CNT_W:0]    elapsed_sum;
	logic [CNT_W-1:0]  elapsed_next;
	logic [CNT_W-1:0]  miss_next;

	logic              back_we;
	logic [MEM_AW-1:0] back_waddr;
	logic [MEM_AW-1:0] back_raddr;
	logic [BYTE_W-1:0] back_rdata;
	logic [LRAM_AW-1:0] lram_waddr;
	logic [LRAM_AW-1:0] lram_raddr;
	logic [BYTE_W-1:0] lram_rdata;

	assign in_addr = s_axis_tdata[ADDR_W-1:0];
	assign in_byte = s_axis_tdata[ADDR_W +: BYTE_W];

	assign offset = addr_q[OFF_W-1:0];
	assign line   = addr_q[OFF_W +: LINE_W];
	assign tag    = addr_q[ADDR_W-1 -: TAG_W];
	assign hit    = valid_q[line] & (tag_q[line] == tag);

	// one unit per read, plus the penalty on a miss
	assign elapsed_sum  = {1'b0, elapsed_q} + (CNT_W+1)'(1)
		+ (hit ? '0 : (CNT_W+1)'(penalty_q));
	assign elapsed_next = elapsed_sum[CNT_W] ? CNT_MAX : elapsed_sum[CNT_W-1:0];
	assign miss_next    = (miss_q == CNT_MAX) ? miss_q : miss_q + CNT_W'(1);

	assign back_we    = cmd.accept & (s_axis_tuser == MODE_LOAD);
	assign back_waddr = MEM_AW'(in_addr);
	assign back_raddr = MEM_AW'({addr_q[ADDR_W-1:OFF_W], fill_cnt_q});
	assign lram_raddr = in_addr[LRAM_AW-1:0];
	assign lram_waddr = {line, fill_idx_s1};

	dmc_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(MEMORY_BYTES)
	) u_back_ram (
		.clk  (clk),
		.we   (back_we),
		.waddr(back_waddr),
		.wdata(in_byte),
		.raddr(back_raddr),
		.rdata(back_rdata)
	);

	dmc_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(NUM_LINES * BLOCK_BYTES)
	) u_line_ram (
		.clk  (clk),
		.we   (fill_pend_s1),
		.waddr(lram_waddr),
		.wdata(back_rdata),
		.raddr(lram_raddr),
		.rdata(lram_rdata)
	);

	assign sts.hit       = hit;
	assign sts.fill_last = (fill_cnt_q == OFF_W'(BLOCK_BYTES - 1));
	assign sts.out_free  = ~m_valid_q | m_axis_tready;

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			addr_q <= in_addr;
			hit_q  <= 1'b0;
			byte_q <= '0;
		end
		if (cmd.lookup) begin
			hit_q <= hit;
			if (hit) begin
				byte_q <= lram_rdata;
			end else begin
				tag_q[line] <= tag;
			end
		end
		if (fill_pend_s1 && (fill_idx_s1 == offset)) begin
			byte_q <= back_rdata;
		end
		fill_idx_s1 <= fill_cnt_q;
		if (cmd.publish) begin
			m_axis_tuser <= hit_q;
			m_axis_tdata <= {elapsed_q, miss_q, byte_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			penalty_q    <= PENALTY_RESET;
			valid_q      <= '0;
			miss_q       <= '0;
			elapsed_q    <= '0;
			fill_cnt_q   <= '0;
			fill_pend_s1 <= 1'b0;
			m_valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				penalty_q <= cfg_wdata;
			end
			if (cmd.lookup) begin
				elapsed_q <= elapsed_next;
				if (!hit) begin
					miss_q        <= miss_next;
					valid_q[line] <= 1'b1;
					fill_cnt_q    <= '0;
				end
			end
			if (cmd.fill_step) begin
				fill_cnt_q <= fill_cnt_q + OFF_W'(1);
			end
			fill_pend_s1 <= cmd.fill_step;
			if (cmd.publish) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = m_valid_q;

endmodule

@@ hdl/direct_mapped_cache.sv @@
// Top level of the direct-mapped read cache: controller plus datapath.
// Depends on dmc_pkg, dmc_ctrl, dmc_datapath (and dmc_ram below it).
//
//   channel  | handshake                    | payload
//   ---------+------------------------------+---------------------------------------
//   s_axis   | s_axis_tvalid/s_axis_tready  | tuser: mode; tdata: address, write_byte
//   m_axis   | m_axis_tvalid/m_axis_tready  | tuser: hit; tdata: read_byte, miss_total,
//            |                              |   elapsed_total
//   cfg      | cfg_we                       | cfg_wdata: miss_penalty
//
// Load word: IDLE, DONE. Read hit: IDLE, LOOKUP, DONE. Read miss: IDLE, LOOKUP, FILL, DRAIN,
// DONE, where FILL copies one byte per cycle from the backing RAM read port into the line RAM.
// One word in flight; the next is taken while the last result waits in the output register.
// Reset: all lines invalid, counters zero, miss_penalty 10; no clearing pass.
module direct_mapped_cache
	import dmc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [9:0] address, [17:10] write_byte, zeros
	input  logic                   s_axis_tuser,  // [0] mode
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // [7:0] read_byte, [39:8] miss_total,
	                                               // [71:40] elapsed_total
	output logic                   m_axis_tuser,  // [0] hit
	input  logic                   cfg_we,
	input  logic [BYTE_W-1:0]      cfg_wdata
);

	dmc_cmd_t cmd;
	dmc_sts_t sts;

	dmc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tuser (s_axis_tuser),
		.sts          (sts),
		.cmd          (cmd)
	);

	dmc_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

endmodule

@@ sim/direct_mapped_cache_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for direct_mapped_cache: a line/tag/counter predictor checks every result word.
// Depends on dmc_pkg and the RTL under hdl/.
module direct_mapped_cache_test;
	import dmc_pkg::*;

	localparam logic MODE_READ = ~MODE_LOAD;
	localparam int   WATCHDOG  = 1000000;
	localparam int   PHASE_LEN = 280;

	class cache_scoreboard;
		typedef struct {
			logic             hit;
			logic [BYTE_W-1:0] rbyte;
			logic [CNT_W-1:0]  misses;
			logic [CNT_W-1:0]  elapsed;
		} cache_word_t;

		logic [BYTE_W-1:0] backing [MEMORY_BYTES];
		bit                written [MEMORY_BYTES];
		bit                line_valid [NUM_LINES];
		logic [TAG_W-1:0]  line_tag [NUM_LINES];
		logic [BYTE_W-1:0] line_bytes [NUM_LINES][BLOCK_BYTES];
		logic [CNT_W-1:0]  misses;
		logic [CNT_W-1:0]  elapsed;
		logic [BYTE_W-1:0] penalty;
		cache_word_t       expected [$];
		int                fail_count;

		function new();
			penalty = PENALTY_RESET;
			misses = '0;
			elapsed = '0;
			fail_count = 0;
			foreach (line_valid[i]) line_valid[i] = 1'b0;
			foreach (written[i]) written[i] = 1'b0;
		endfunction

		function logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] a, logic [CNT_W-1:0] b);
			logic [CNT_W:0] s;
			s = {1'b0, a} + {1'b0, b};
			return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
		endfunction

		function bit would_hit(logic [ADDR_W-1:0] a);
			logic [LINE_W-1:0] ln;
			ln = a[OFF_W +: LINE_W];
			return line_valid[ln] && line_tag[ln] == a[ADDR_W-1 -: TAG_W];
		endfunction

		function void note_word(logic mode, logic [ADDR_W-1:0] a, logic [BYTE_W-1:0] wb);
			cache_word_t       r;
			logic [LINE_W-1:0] ln;
			int                base;
			ln = a[OFF_W +: LINE_W];
			base = int'({a[ADDR_W-1:OFF_W], {OFF_W{1'b0}}});
			r.hit = 1'b0;
			r.rbyte = '0;
			if (mode == MODE_LOAD) begin
				backing[a] = wb;
				written[a] = 1'b1;
			end else begin
				elapsed = sat_add(elapsed, 1);
				if (would_hit(a)) begin
					r.hit = 1'b1;
				end else begin
					misses = sat_add(misses, 1);
					elapsed = sat_add(elapsed, CNT_W'(penalty));
					for (int i = 0; i < BLOCK_BYTES; i++)
						line_bytes[ln][i] = backing[(base + i) % MEMORY_BYTES];
					line_tag[ln] = a[ADDR_W-1 -: TAG_W];
					line_valid[ln] = 1'b1;
				end
				r.rbyte = line_bytes[ln][a[OFF_W-1:0]];
			end
			r.misses = misses;
			r.elapsed = elapsed;
			expected.push_back(r);
		endfunction

		function void flag(string msg);
			fail_count++;
			if (fail_count <= 10)
				$display("%0t: %s", $realtime, msg);
		endfunction

		function void check_word(logic hit, logic [BYTE_W-1:0] rbyte,
				logic [CNT_W-1:0] mc, logic [CNT_W-1:0] et);
			cache_word_t r;
			if (expected.size() == 0) begin
				flag($sformatf("unexpected word: hit %0d byte %0h misses %0d elapsed %0d",
					hit, rbyte, mc, et));
				return;
			end
			r = expected.pop_front();
			if (hit !== r.hit)
				flag($sformatf("hit: expected %0d, got %0d", r.hit, hit));
			if (rbyte !== r.rbyte)
				flag($sformatf("read_byte: expected %0h, got %0h", r.rbyte, rbyte));
			if (mc !== r.misses)
				flag($sformatf("miss_total: expected %0d, got %0d", r.misses, mc));
			if (et !== r.elapsed)
				flag($sformatf("elapsed_total: expected %0d, got %0d", r.elapsed, et));
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                   s_axis_tuser = 1'b0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tuser;
	logic                   cfg_we = 1'b0;
	logic [BYTE_W-1:0]      cfg_wdata = '0;

	cache_scoreboard   sb;
	int                tx_idle_pct = 0;
	int                rx_stall_pct = 0;
	int                hold_request = 0;
	int                hold_left = 0;
	int                words_sent = 0;
	int                cycle_count = 0;
	logic [ADDR_W-1:0] recent = '0;

	direct_mapped_cache uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == WATCHDOG) begin
			$display("status: fail");
			$finish;
		end
	end

	// result side: check accepted words, then pick next tready (long hold-off when requested)
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			sb.check_word(m_axis_tuser, m_axis_tdata[BYTE_W-1:0], m_axis_tdata[BYTE_W +: CNT_W],
				m_axis_tdata[BYTE_W+CNT_W +: CNT_W]);
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	task automatic send_word(logic mode, logic [ADDR_W-1:0] a, logic [BYTE_W-1:0] wb);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= mode;
		s_axis_tdata <= IN_TDATA_W'({wb, a});
		do @(posedge clk); while (!s_axis_tready);
		sb.note_word(mode, a, wb);
		words_sent++;
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.expected.size() != 0) @(posedge clk);
	endtask

	task automatic set_penalty(logic [BYTE_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		sb.penalty = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic load_block(logic [ADDR_W-1:0] a);
		for (int i = 0; i < BLOCK_BYTES; i++)
			send_word(MODE_LOAD, {a[ADDR_W-1:OFF_W], OFF_W'(i)}, BYTE_W'($urandom));
	endtask

	// a miss must never fill from unwritten backing bytes: load the gaps first
	task automatic read_through(logic [ADDR_W-1:0] a);
		logic [ADDR_W-1:0] b;
		if (!sb.would_hit(a)) begin
			for (int i = 0; i < BLOCK_BYTES; i++) begin
				b = {a[ADDR_W-1:OFF_W], OFF_W'(i)};
				if (!sb.written[b])
					send_word(MODE_LOAD, b, BYTE_W'($urandom));
			end
		end
		send_word(MODE_READ, a, BYTE_W'($urandom));
		recent = a;
	endtask

	task automatic random_step();
		int                pick;
		logic [ADDR_W-1:0] a;
		pick = $urandom_range(99);
		a = ADDR_W'($urandom);
		if (pick < 15) begin
			send_word(MODE_LOAD, a, BYTE_W'($urandom));
		end else if (pick < 35) begin
			load_block(a);
			repeat ($urandom_range(1, 3))
				read_through({a[ADDR_W-1:OFF_W], OFF_W'($urandom)});
		end else if (pick < 60) begin
			read_through({recent[ADDR_W-1:OFF_W], OFF_W'($urandom)});
		end else if (pick < 75) begin
			// same line, random tag: an eviction unless the tag repeats
			read_through({TAG_W'($urandom), recent[OFF_W +: LINE_W], OFF_W'($urandom)});
		end else begin
			read_through(a);
		end
	endtask

	initial begin
		int                tx_tbl [5] = '{0, 55, 0, 20, 0};
		int                rx_tbl [5] = '{0, 0, 55, 20, 0};
		int                target;
		logic [BYTE_W-1:0] pen;
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// cold miss on first and last block, hits at both offset ends, stale line after a load
		for (int i = 0; i < BLOCK_BYTES; i++)
			send_word(MODE_LOAD, ADDR_W'(i),
				(i == 0) ? 8'h00 : (i == BLOCK_BYTES - 1) ? 8'hFF : BYTE_W'($urandom));
		send_word(MODE_READ, ADDR_W'(0), 8'hFF);
		send_word(MODE_READ, ADDR_W'(BLOCK_BYTES - 1), 8'h00);
		for (int i = 0; i < BLOCK_BYTES; i++)
			send_word(MODE_LOAD, ADDR_W'(MEMORY_BYTES - BLOCK_BYTES + i), BYTE_W'($urandom));
		send_word(MODE_READ, ADDR_W'(MEMORY_BYTES - 1), BYTE_W'($urandom));
		send_word(MODE_READ, ADDR_W'(MEMORY_BYTES - BLOCK_BYTES), BYTE_W'($urandom));
		send_word(MODE_LOAD, ADDR_W'(MEMORY_BYTES - 1), 8'hFF);
		send_word(MODE_READ, ADDR_W'(MEMORY_BYTES - 1), BYTE_W'($urandom));
		send_word(MODE_READ, ADDR_W'(0), BYTE_W'($urandom));
		drain();

		for (int p = 0; p < 5; p++) begin
			case (p)
				0: pen = 8'd0;
				1: pen = 8'd255;
				3: pen = 8'd1;
				default: pen = BYTE_W'($urandom);
			endcase
			set_penalty(pen);
			tx_idle_pct = tx_tbl[p];
			rx_stall_pct = rx_tbl[p];
			if (p == 4)
				hold_request = 400;
			target = words_sent + PHASE_LEN;
			while (words_sent < target)
				random_step();
			drain();
		end

		rx_stall_pct = 0;
		repeat (40) @(posedge clk);
		if (sb.fail_count == 0 && sb.expected.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
